>>> src/tpi_pkg.sv
// ----------------------------------------------------------------------------
// tpi_pkg
// Shared widths, constants and types for the three-plane intersection block.
// ----------------------------------------------------------------------------
package tpi_pkg;

   localparam int NRM_W    = 16;   // Q1.14 normal component
   localparam int DST_W    = 24;   // Q15.8 plane offset
   localparam int PNT_W    = 32;   // Q23.8 result
   localparam int PRD_W    = 32;   // normal x normal product
   localparam int CRS_W    = 33;   // cross product component
   localparam int DPR_W    = 49;   // normal x cross product
   localparam int NPR_W    = 57;   // distance x cross product
   localparam int DEN_W    = 50;   // determinant
   localparam int NUM_W    = 59;   // numerator sum
   localparam int MAG_W    = 58;   // numerator magnitude
   localparam int DVS_W    = 49;   // determinant magnitude
   localparam int FRAC_SH  = 14;   // Q36 / Q42 -> Q8 scale
   localparam int REM_W    = MAG_W + FRAC_SH;
   localparam int QUO_W    = 32;
   localparam int DIV_STEPS = QUO_W;
   localparam int SHD_W    = DVS_W + QUO_W - 1;
   localparam int OVF_SH   = QUO_W - FRAC_SH;

   localparam int QDEPTH   = 8;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int QCNT_W   = $clog2(QDEPTH + 1);

   localparam logic [PNT_W:0] POS_LIMIT = {2'b00, {(PNT_W - 1){1'b1}}};
   localparam logic [PNT_W:0] NEG_LIMIT = {2'b01, {(PNT_W - 1){1'b0}}};

   typedef struct packed {
      logic signed [NRM_W-1:0] n1x, n1y, n1z;
      logic signed [NRM_W-1:0] n2x, n2y, n2z;
      logic signed [NRM_W-1:0] n3x, n3y, n3z;
      logic signed [DST_W-1:0] d1, d2, d3;
   } tpi_req_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] num_x;
      logic signed [NUM_W-1:0] num_y;
      logic signed [NUM_W-1:0] num_z;
      logic signed [DEN_W-1:0] den;
   } tpi_item_type;

endpackage

>>> src/tpi_front.sv
// ----------------------------------------------------------------------------
// tpi_front
// Four-stage pipeline: cross products, determinant and numerator sums.
// ----------------------------------------------------------------------------
module tpi_front
   import tpi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  tpi_req_type  in_req,
   output logic         out_valid,
   output tpi_item_type out_item
);

   logic signed [NRM_W-1:0] nrm [3][3];
   logic signed [DST_W-1:0] dst [3];

   logic                    v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [PRD_W-1:0] prd_ff [3][6];
   logic signed [PRD_W-1:0] prd_in [3][6];
   logic signed [NRM_W-1:0] n1_s1_ff [3];
   logic signed [NRM_W-1:0] n1_s2_ff [3];
   logic signed [DST_W-1:0] d_s1_ff [3];
   logic signed [DST_W-1:0] d_s2_ff [3];
   logic signed [CRS_W-1:0] crs_ff [3][3];
   logic signed [CRS_W-1:0] crs_in [3][3];
   logic signed [DPR_W-1:0] dpr_ff [3];
   logic signed [DPR_W-1:0] dpr_in [3];
   logic signed [NPR_W-1:0] npr_ff [3][3];
   logic signed [NPR_W-1:0] npr_in [3][3];
   tpi_item_type            item_ff, item_in;

   localparam int NXT [3] = '{1, 2, 0};
   localparam int NN  [3] = '{2, 0, 1};

   always_comb begin
      nrm[0] = '{in_req.n1x, in_req.n1y, in_req.n1z};
      nrm[1] = '{in_req.n2x, in_req.n2y, in_req.n2z};
      nrm[2] = '{in_req.n3x, in_req.n3y, in_req.n3z};
      dst    = '{in_req.d1, in_req.d2, in_req.d3};
   end

   // c[i] = n[i+1] x n[i+2], products first
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prd_in[i][0] = PRD_W'(nrm[NXT[i]][1]) * PRD_W'(nrm[NN[i]][2]);
         prd_in[i][1] = PRD_W'(nrm[NXT[i]][2]) * PRD_W'(nrm[NN[i]][1]);
         prd_in[i][2] = PRD_W'(nrm[NXT[i]][2]) * PRD_W'(nrm[NN[i]][0]);
         prd_in[i][3] = PRD_W'(nrm[NXT[i]][0]) * PRD_W'(nrm[NN[i]][2]);
         prd_in[i][4] = PRD_W'(nrm[NXT[i]][0]) * PRD_W'(nrm[NN[i]][1]);
         prd_in[i][5] = PRD_W'(nrm[NXT[i]][1]) * PRD_W'(nrm[NN[i]][0]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            crs_in[i][k] = CRS_W'(prd_ff[i][2*k]) - CRS_W'(prd_ff[i][2*k+1]);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dpr_in[k] = DPR_W'(n1_s2_ff[k]) * DPR_W'(crs_ff[0][k]);
         for (int i = 0; i < 3; i++) begin
            npr_in[i][k] = NPR_W'(d_s2_ff[i]) * NPR_W'(crs_ff[i][k]);
         end
      end
   end

   always_comb begin
      item_in.den   = DEN_W'(dpr_ff[0]) + DEN_W'(dpr_ff[1]) + DEN_W'(dpr_ff[2]);
      item_in.num_x = NUM_W'(npr_ff[0][0]) + NUM_W'(npr_ff[1][0]) + NUM_W'(npr_ff[2][0]);
      item_in.num_y = NUM_W'(npr_ff[0][1]) + NUM_W'(npr_ff[1][1]) + NUM_W'(npr_ff[2][1]);
      item_in.num_z = NUM_W'(npr_ff[0][2]) + NUM_W'(npr_ff[1][2]) + NUM_W'(npr_ff[2][2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      prd_ff   <= prd_in;
      n1_s1_ff <= nrm[0];
      d_s1_ff  <= dst;
      crs_ff   <= crs_in;
      n1_s2_ff <= n1_s1_ff;
      d_s2_ff  <= d_s1_ff;
      dpr_ff   <= dpr_in;
      npr_ff   <= npr_in;
      item_ff  <= item_in;
   end

   assign out_valid = v4_ff;
   assign out_item  = item_ff;

endmodule

>>> src/tpi_queue.sv
// ----------------------------------------------------------------------------
// tpi_queue
// Short FIFO between the front pipeline and the divider back end.
// ----------------------------------------------------------------------------
module tpi_queue
   import tpi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  tpi_item_type push_item,
   input  logic         pop,
   output logic         not_empty,
   output tpi_item_type head_item
);

   tpi_item_type      mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_item;
   end

   assign not_empty = (cnt_ff != '0);
   assign head_item = mem_ff[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> cnt_ff != QCNT_W'(QDEPTH))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0)
      else $error("queue underflow");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != QCNT_W'(QDEPTH) |-> QPTR_W'(wr_ptr_ff - rd_ptr_ff) == cnt_ff[QPTR_W-1:0])
      else $error("queue pointers disagree with count");

endmodule

>>> src/tpi_div_lane.sv
// ----------------------------------------------------------------------------
// tpi_div_lane
// Pipelined restoring divider: floor((a << 14) / b), one quotient bit per stage.
// ----------------------------------------------------------------------------
module tpi_div_lane
   import tpi_pkg::*;
(
   input  logic             clock,
   input  logic             adv,
   input  logic [MAG_W-1:0] mag_a,
   input  logic [DVS_W-1:0] mag_b,
   output logic [QUO_W-1:0] quo,
   output logic [DVS_W-1:0] rem,
   output logic [DVS_W-1:0] dvs,
   output logic             ovf
);

   logic [REM_W-1:0] rem_ff [DIV_STEPS+1];
   logic [DVS_W-1:0] dvs_ff [DIV_STEPS+1];
   logic [QUO_W-1:0] quo_ff [DIV_STEPS+1];
   logic             ovf_ff [DIV_STEPS+1];

   // quotient needs more than QUO_W bits when a >= b << 18
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= {mag_a, {FRAC_SH{1'b0}}};
         dvs_ff[0] <= mag_b;
         quo_ff[0] <= '0;
         ovf_ff[0] <= ({{OVF_SH{1'b0}}, mag_a} >= {mag_b, {OVF_SH{1'b0}}});
      end
   end

   for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
      localparam int K = DIV_STEPS - j;
      logic [SHD_W-1:0] shd;
      logic             ge;
      always_comb begin
         shd = SHD_W'(dvs_ff[j-1]) << K;
         ge  = (SHD_W'(rem_ff[j-1]) >= shd);
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j] <= ge ? REM_W'(SHD_W'(rem_ff[j-1]) - shd) : rem_ff[j-1];
            dvs_ff[j] <= dvs_ff[j-1];
            quo_ff[j] <= {quo_ff[j-1][QUO_W-2:0], ge};
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end
   end

   assign quo = quo_ff[DIV_STEPS];
   assign rem = rem_ff[DIV_STEPS][DVS_W-1:0];
   assign dvs = dvs_ff[DIV_STEPS];
   assign ovf = ovf_ff[DIV_STEPS];

endmodule

>>> src/tpi_back.sv
// ----------------------------------------------------------------------------
// tpi_back
// Sign handling, three divider lanes, rounding, saturation and output register.
// ----------------------------------------------------------------------------
module tpi_back
   import tpi_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  tpi_item_type            in_item,
   output logic                    in_pop,
   output logic                    out_valid,
   input  logic                    out_stall,
   output logic signed [PNT_W-1:0] out_x,
   output logic signed [PNT_W-1:0] out_y,
   output logic signed [PNT_W-1:0] out_z,
   output logic                    out_found
);

   logic                    adv;
   logic signed [NUM_W-1:0] num [3];
   logic                    den_neg;
   logic [DVS_W-1:0]        mag_b;
   logic [MAG_W-1:0]        mag_a [3];
   logic [QUO_W-1:0]        quo [3];
   logic [DVS_W-1:0]        rem [3];
   logic [DVS_W-1:0]        dvs [3];
   logic                    ovf [3];

   logic                    vld_ff   [DIV_STEPS+1];
   logic                    fnd_ff   [DIV_STEPS+1];
   logic [2:0]              neg_ff   [DIV_STEPS+1];
   logic [2:0]              zro_ff   [DIV_STEPS+1];

   logic                    rsp_valid_ff;
   logic signed [PNT_W-1:0] pnt_ff [3];
   logic signed [PNT_W-1:0] pnt_in [3];
   logic                    fnd_out_ff;
   logic [PNT_W:0]          mag_m [3];

   assign adv    = !rsp_valid_ff || !out_stall;
   assign in_pop = adv && in_valid;

   always_comb begin
      num     = '{in_item.num_x, in_item.num_y, in_item.num_z};
      den_neg = in_item.den[DEN_W-1];
      mag_b   = den_neg ? DVS_W'(-in_item.den) : DVS_W'(in_item.den);
      for (int k = 0; k < 3; k++) begin
         mag_a[k] = num[k][NUM_W-1] ? MAG_W'(-num[k]) : MAG_W'(num[k]);
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_lane
      tpi_div_lane u_lane (
         .clock (clock),
         .adv   (adv),
         .mag_a (mag_a[k]),
         .mag_b (mag_b),
         .quo   (quo[k]),
         .rem   (rem[k]),
         .dvs   (dvs[k]),
         .ovf   (ovf[k])
      );
   end

   // side band rides alongside the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= DIV_STEPS; j++) vld_ff[j] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int j = 1; j <= DIV_STEPS; j++) vld_ff[j] <= vld_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fnd_ff[0] <= (in_item.den != '0);
         for (int k = 0; k < 3; k++) begin
            // leading minus of the formula flips the quotient sign
            neg_ff[0][k] <= !(num[k][NUM_W-1] ^ den_neg);
            zro_ff[0][k] <= (num[k] == '0);
         end
         for (int j = 1; j <= DIV_STEPS; j++) begin
            fnd_ff[j] <= fnd_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
            zro_ff[j] <= zro_ff[j-1];
         end
      end
   end

   // round half away from zero, then saturate
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mag_m[k] = {1'b0, quo[k]} +
                    (PNT_W+1)'({rem[k], 1'b0} >= {1'b0, dvs[k]});
         if (!fnd_ff[DIV_STEPS] || zro_ff[DIV_STEPS][k]) begin
            pnt_in[k] = '0;
         end else if (neg_ff[DIV_STEPS][k]) begin
            if (ovf[k] || mag_m[k] > NEG_LIMIT) pnt_in[k] = PNT_W'(-NEG_LIMIT);
            else                                pnt_in[k] = PNT_W'(-mag_m[k]);
         end else begin
            if (ovf[k] || mag_m[k] > POS_LIMIT) pnt_in[k] = PNT_W'(POS_LIMIT);
            else                                pnt_in[k] = PNT_W'(mag_m[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pnt_ff     <= pnt_in;
         fnd_out_ff <= fnd_ff[DIV_STEPS];
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_x     = pnt_ff[0];
   assign out_y     = pnt_ff[1];
   assign out_z     = pnt_ff[2];
   assign out_found = fnd_out_ff;

endmodule

>>> src/three_plane_intersection.sv
// ----------------------------------------------------------------------------
// three_plane_intersection
// Intersection point of three planes n.p + d = 0 in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: three Q1.14 normals and three Q15.8 offsets.
//   rsp_* returns one item per request: point_x/y/z in Q23.8, saturated,
//   and found, which is low (with a zero point) when the determinant is zero.
//   Both channels use valid/stall; a transfer happens when valid is high and
//   stall is low.
// Path: front pipeline, then the queue, then the divider (operand setup stage
//   plus 32 stages, one quotient bit each), then the output register.
// Throughput: one item per cycle while rsp_stall is low. The divider lanes are
//   fully pipelined and the front pipeline never stalls.
// Stall: the back end freezes while rsp_stall holds a valid result. The
//   front keeps accepting until 8 items are outstanding between acceptance
//   and the back end; req_stall then rises until the back end drains one.
// Reset: synchronous; empties all pipelines and the queue. No state survives
//   an item, so no configuration or warm-up is needed.
// ----------------------------------------------------------------------------
module three_plane_intersection
   import tpi_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [NRM_W-1:0] req_first_normal_x,
   input  logic signed [NRM_W-1:0] req_first_normal_y,
   input  logic signed [NRM_W-1:0] req_first_normal_z,
   input  logic signed [NRM_W-1:0] req_second_normal_x,
   input  logic signed [NRM_W-1:0] req_second_normal_y,
   input  logic signed [NRM_W-1:0] req_second_normal_z,
   input  logic signed [NRM_W-1:0] req_third_normal_x,
   input  logic signed [NRM_W-1:0] req_third_normal_y,
   input  logic signed [NRM_W-1:0] req_third_normal_z,
   input  logic signed [DST_W-1:0] req_first_distance,
   input  logic signed [DST_W-1:0] req_second_distance,
   input  logic signed [DST_W-1:0] req_third_distance,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [PNT_W-1:0] rsp_point_x,
   output logic signed [PNT_W-1:0] rsp_point_y,
   output logic signed [PNT_W-1:0] rsp_point_z,
   output logic                    rsp_found
);

   tpi_req_type       req;
   logic              accept;
   logic              front_valid;
   tpi_item_type      front_item;
   logic              q_not_empty;
   tpi_item_type      q_head;
   logic              q_pop;
   // items accepted but not yet taken by the back end (front + queue)
   logic [QCNT_W-1:0] outstanding_ff;

   always_comb begin
      req.n1x = req_first_normal_x;
      req.n1y = req_first_normal_y;
      req.n1z = req_first_normal_z;
      req.n2x = req_second_normal_x;
      req.n2y = req_second_normal_y;
      req.n2z = req_second_normal_z;
      req.n3x = req_third_normal_x;
      req.n3y = req_third_normal_y;
      req.n3z = req_third_normal_z;
      req.d1  = req_first_distance;
      req.d2  = req_second_distance;
      req.d3  = req_third_distance;
   end

   // credit check keeps the queue from ever overflowing
   assign req_stall = (outstanding_ff == QCNT_W'(QDEPTH));
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else if (accept && !q_pop) begin
         outstanding_ff <= outstanding_ff + 1'b1;
      end else if (q_pop && !accept) begin
         outstanding_ff <= outstanding_ff - 1'b1;
      end
   end

   tpi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_req    (req),
      .out_valid (front_valid),
      .out_item  (front_item)
   );

   tpi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_item (front_item),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (q_head)
   );

   tpi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_not_empty),
      .in_item   (q_head),
      .in_pop    (q_pop),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_x     (rsp_point_x),
      .out_y     (rsp_point_y),
      .out_z     (rsp_point_z),
      .out_found (rsp_found)
   );

endmodule
